[hw/rtl/sha256_stream_hasher_core_assert.svh]
// Assertion macros for the SHA-256 stream hasher core.
`ifndef SHA256_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_STREAM_HASHER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[hw/rtl/shs_pkg.sv]
// Shared constants, types and functions of the SHA-256 stream hasher.
package shs_pkg;
   localparam int BYTES_PER_ITEM_DEF = 4;
   localparam int WORD_BYTES = 4;
   localparam int BLOCK_BYTES = 64;
   localparam int LENGTH_AT = 56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef logic [31:0] word_type;

   // Control from sequencer to round unit.
   typedef struct packed {
      logic       load;    // copy hash words into working variables
      logic       round;   // run one round
      logic       fold;    // add working variables into hash words
      logic       init;    // reload initial hash values
      logic [5:0] index;   // round index
   } rnd_ctl_type;

   function automatic word_type init_word(input logic [2:0] i);
      word_type r;
      unique case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
      32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
      32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
      32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
      32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
      32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
      32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
      32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
      32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type ror(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction
endpackage

[hw/rtl/shs_round.sv]
// SHA-256 round unit: message schedule window, working variables and hash words.
module shs_round (
   input  logic                 clock,
   input  logic                 reset,
   input  shs_pkg::rnd_ctl_type ctl,
   input  shs_pkg::word_type    block_word,   // schedule word for rounds 0..15
   input  logic [2:0]           hash_sel,
   output shs_pkg::word_type    hash_word
);
   import shs_pkg::*;

   word_type w_ff [16];
   word_type w_in [16];
   word_type v_ff [8];
   word_type v_in [8];
   word_type h_ff [8];
   word_type h_in [8];
   word_type wt, s0w, s1w, t1, s0, s1, ch, mj;

   // Schedule word: first sixteen from the buffer, then expand from the window.
   always_comb begin
      s0w = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      if (ctl.index < 6'd16) begin
         wt = block_word;
      end else begin
         wt = s1w + w_ff[9] + s0w + w_ff[0];
      end
      s1 = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + ROUND_K[ctl.index] + wt;
      s0 = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   end

   // Advance window and working variables; load, fold and reload the hash words.
   always_comb begin
      w_in = w_ff;
      v_in = v_ff;
      h_in = h_ff;
      if (ctl.load) begin
         v_in = h_ff;
      end
      if (ctl.round) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wt;
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + s0 + mj;
      end
      if (ctl.fold) begin
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
      if (ctl.init) begin
         for (int i = 0; i < 8; i++) h_in[i] = init_word(3'(i));
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_word(3'(i));
      end else begin
         h_ff <= h_in;
      end
   end

   assign hash_word = h_ff[hash_sel];
endmodule

[hw/rtl/sha256_stream_hasher_core.sv]
// Top level of the SHA-256 stream hasher: byte buffer, sequencer and output stage.
// An item is accepted, written one byte a cycle into the block buffer (paused by any
// compression) and then closed; every 64th byte starts a compression through the
// one-round-per-cycle unit (load, 64 rounds, fold), during which req_tready is low. A last
// item then pads one byte a cycle, with one or two further compressions, and emits the
// eight digest words on rsp_, one per accepted transaction.
module sha256_stream_hasher_core #(
   parameter int BYTES_PER_ITEM = shs_pkg::BYTES_PER_ITEM_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_word[31:0], byte_count[34:32], zeros
   input  logic        req_tlast,   // last_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word[31:0]
   output logic        rsp_tlast    // last_word
);
   import shs_pkg::*;
   `include "sha256_stream_hasher_core_assert.svh"

   localparam int NMAX = (BYTES_PER_ITEM < WORD_BYTES) ? BYTES_PER_ITEM : WORD_BYTES;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_FEED = 6'b000010,
      ST_PAD  = 6'b000100,
      ST_COMP = 6'b001000,
      ST_OUT  = 6'b010000,
      ST_INIT = 6'b100000
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] total_ff, total_in;
   logic [6:0]  step_ff, step_in;
   logic [2:0]  osel_ff, osel_in;
   logic [3:0]  pad_ff, pad_in;      // 0: mark, 1: zeros, 2: length
   word_type    buf_mem [BLOCK_BYTES / WORD_BYTES];
   logic        wr_en;
   logic [7:0]  wr_byte;
   word_type    blk_word_ff;
   logic [2:0]  cnt_sat;
   logic [63:0] bits;
   rnd_ctl_type ctl;
   word_type    hash_word;

   shs_round u_round (
      .clock(clock), .reset(reset), .ctl(ctl), .block_word(blk_word_ff),
      .hash_sel(osel_ff), .hash_word(hash_word)
   );

   always_comb begin
      cnt_sat = req_tdata[34:32];
      if (cnt_sat > 3'(NMAX)) cnt_sat = 3'(NMAX);
      bits = {total_ff, 3'b000};
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      data_in = data_ff; cnt_in = cnt_ff; last_in = last_ff;
      fill_in = fill_ff; total_in = total_ff; step_in = step_ff;
      osel_in = osel_ff; pad_in = pad_ff;
      wr_en = 1'b0; wr_byte = 8'h00;
      ctl = '0;
      ctl.index = step_ff[5:0] - 6'd1;
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               data_in = req_tdata[31:0];
               cnt_in = cnt_sat;
               last_in = req_tlast;
               total_in = total_ff + 61'(cnt_sat);
               pad_in = 4'd0;
               state_in = ST_FEED;
            end
         end
         ST_FEED, ST_PAD: begin
            if (state_ff == ST_FEED && cnt_ff == 3'd0) begin
               state_in = last_ff ? ST_PAD : ST_IDLE;
            end else begin
               wr_en = 1'b1;
               if (state_ff == ST_FEED) begin
                  wr_byte = data_ff[31:24];
                  data_in = data_ff << 8;
                  cnt_in = cnt_ff - 3'd1;
               end else if (pad_ff == 4'd0) begin
                  wr_byte = PAD_MARK;
                  pad_in = 4'd1;
               end else if (pad_ff == 4'd2) begin
                  wr_byte = bits[63 - 8*(fill_ff[2:0]) -: 8];
               end
               fill_in = fill_ff + 6'd1;
               if (state_ff == ST_PAD && fill_ff == 6'd63 && pad_ff == 4'd2) begin
                  ret_in = ST_OUT;
               end else begin
                  ret_in = state_ff;
               end
               if (state_ff == ST_PAD && pad_ff != 4'd0 && fill_ff == 6'(LENGTH_AT - 1))
                  pad_in = 4'd2;
               if (state_ff == ST_PAD && pad_ff == 4'd0 && fill_ff == 6'(LENGTH_AT - 1))
                  pad_in = 4'd2;
               if (fill_ff == 6'd63) begin
                  state_in = ST_COMP;
                  step_in = 7'd0;
               end
            end
         end
         ST_COMP: begin
            step_in = step_ff + 7'd1;
            if (step_ff == 7'd0) begin
               ctl.load = 1'b1;
            end else if (step_ff <= 7'd64) begin
               ctl.round = 1'b1;
            end else begin
               ctl.fold = 1'b1;
               osel_in = 3'd0;
               state_in = (ret_ff == ST_OUT) ? ST_OUT : ret_ff;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               osel_in = osel_ff + 3'd1;
               if (osel_ff == 3'd7) state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            ctl.init = 1'b1;
            fill_in = 6'd0; total_in = '0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         fill_ff <= '0;
         total_ff <= '0;
         step_ff <= '0;
         osel_ff <= '0;
         pad_ff <= '0;
         cnt_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         fill_ff <= fill_in;
         total_ff <= total_in;
         step_ff <= step_in;
         osel_ff <= osel_in;
         pad_ff <= pad_in;
         cnt_ff <= cnt_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Block buffer of sixteen words, written one byte lane at a time; read one big-endian
   // word ahead of each of the first sixteen rounds.
   logic [3:0] rd_idx;
   assign rd_idx = (step_in[5:0] >= 6'd1) ? 4'(step_in[5:0] - 6'd1) : 4'd0;
   always_ff @(posedge clock) begin
      if (wr_en) buf_mem[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      blk_word_ff <= buf_mem[rd_idx];
   end

   assign rsp_tdata = hash_word;
   assign rsp_tlast = (osel_ff == 3'd7);

   `SHS_ASSERT_IMP(a_ready_idle, clock, reset, req_tready, rsp_tvalid == 1'b0)
   `SHS_ASSERT_NEXT(a_comp_from_full, clock, reset,
      (state_ff == ST_FEED || state_ff == ST_PAD) && wr_en && fill_ff == 6'd63,
      state_ff == ST_COMP)
   `SHS_ASSERT_NEXT(a_init_after_last, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tlast, state_ff == ST_INIT)
endmodule
